FILE: rtl/core/urh_pkg.sv
// ============================================================================
// Root hub port control package
// Shared types and codes for the root hub port controller and its datapath.
// ============================================================================
package urh_pkg;

    // Request codes carried on func.
    localparam logic [3:0] FN_CONNECT  = 4'd0;
    localparam logic [3:0] FN_CLR_HUB  = 4'd1;
    localparam logic [3:0] FN_CLR_PORT = 4'd2;
    localparam logic [3:0] FN_GET_HUB  = 4'd3;
    localparam logic [3:0] FN_GET_PORT = 4'd4;
    localparam logic [3:0] FN_SET_HUB  = 4'd5;
    localparam logic [3:0] FN_SET_PORT = 4'd6;
    localparam logic [3:0] FN_POLL     = 4'd7;
    localparam logic [3:0] FN_TICK     = 4'd8;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PORT_COUNT = 2'd0;
    localparam logic [1:0] CFG_RUNNING    = 2'd1;
    localparam logic [1:0] CFG_RESET_TICK = 2'd2;
    localparam logic [1:0] CFG_RESUME_TICK = 2'd3;

    // Port feature selectors with special handling.
    localparam logic [4:0] FEAT_ENABLE  = 5'd1;
    localparam logic [4:0] FEAT_SUSPEND = 5'd2;
    localparam logic [4:0] FEAT_RESET   = 5'd4;
    localparam logic [4:0] FEAT_POWER   = 5'd8;
    localparam logic [4:0] FEAT_C_CONN  = 5'd16;

    // Port status word bits; change bits live in the upper half.
    localparam logic [31:0] ST_CONN   = 32'h0000_0001;
    localparam logic [31:0] ST_ENABLE = 32'h0000_0002;
    localparam logic [31:0] ST_SUSP   = 32'h0000_0004;
    localparam logic [31:0] ST_RESET  = 32'h0000_0010;
    localparam logic [31:0] ST_POWER  = 32'h0000_0100;
    localparam logic [31:0] ST_LOW    = 32'h0000_0200;
    localparam logic [31:0] ST_HIGH   = 32'h0000_0400;
    localparam logic [31:0] CH_CONN   = 32'h0001_0000;
    localparam logic [31:0] CH_SUSP   = 32'h0004_0000;
    localparam logic [31:0] CH_RESET  = 32'h0010_0000;

    // Attached device states.
    localparam logic [2:0] DEV_NONE     = 3'd0;
    localparam logic [2:0] DEV_ATTACHED = 3'd1;
    localparam logic [2:0] DEV_POWERED  = 3'd2;
    localparam logic [2:0] DEV_DEFAULT  = 3'd3;
    localparam logic [2:0] DEV_SUSP     = 3'd4;

    // Device speeds.
    localparam logic [1:0] SPD_NONE = 2'd0;
    localparam logic [1:0] SPD_LOW  = 2'd1;
    localparam logic [1:0] SPD_HIGH = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } urh_cmd_t;

endpackage

FILE: rtl/core/urh_ctrl.sv
// ============================================================================
// Root hub port controller sequencer
// Steps each request through capture, execute and result strobe.
// ============================================================================
module urh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output urh_pkg::urh_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:  state_next = S_RESP;
            S_RESP:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = (state_reg == S_RESP);
    assign cmd.capture = (state_reg == S_IDLE) && start;
    assign cmd.execute = (state_reg == S_EXEC);

endmodule

FILE: rtl/core/urh_dpath.sv
// ============================================================================
// Root hub port datapath
// Holds the configuration, the per-port state and the result registers.
// ============================================================================
module urh_dpath #(
    parameter int MAX_PORTS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  urh_pkg::urh_cmd_t cmd,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic [3:0]        func,
    input  logic [4:0]        port_number,
    input  logic [4:0]        feature,
    input  logic [2:0]        device_speed,
    output logic              stall_res,
    output logic [15:0]       port_status,
    output logic [15:0]       port_change,
    output logic [8:0]        change_bitmap,
    output logic [2:0]        bitmap_bytes,
    output logic              change_pending
);

    localparam int PW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
    localparam int BM = 9;

    // Configuration.
    logic [3:0]  port_count_reg;
    logic        running_reg;
    logic [15:0] reset_ticks_reg;
    logic [15:0] resume_ticks_reg;

    // Captured request.
    logic [3:0] func_reg;
    logic [4:0] pn_reg;
    logic [4:0] feat_reg;
    logic [2:0] speed_reg;

    // Per-port state.
    logic [31:0] st_reg  [MAX_PORTS];
    logic [2:0]  dev_reg [MAX_PORTS];
    logic [1:0]  spd_reg [MAX_PORTS];
    logic        lat_reg [MAX_PORTS];
    logic        rsm_reg [MAX_PORTS];
    logic [15:0] cd_reg  [MAX_PORTS];

    // Result registers.
    logic        stall_reg;
    logic [15:0] status_reg;
    logic [15:0] change_reg;
    logic [8:0]  bitmap_reg;
    logic [2:0]  bytes_reg;
    logic        pend_reg;

    logic [4:0]    nu;
    logic          port_ok;
    logic [PW-1:0] p;
    logic          wr;
    logic [31:0]   s;
    logic [2:0]    d;
    logic [1:0]    sp;
    logic [31:0]   ns;
    logic [2:0]    nd;
    logic [1:0]    nsp;
    logic          nl;
    logic          nr;
    logic [15:0]   nc;
    logic          stall_next;
    logic          pend_next;
    logic [8:0]    bitmap_next;
    logic [2:0]    bytes_next;
    logic          hub_req;
    logic [31:0]   chosen;

    function automatic logic [31:0] apply_connect(input logic [31:0] w, input logic [1:0] v);
        logic [31:0] r;
        r = w;
        if (w[8])
        begin
            case (v)
                2'd0:    r = r & ~(urh_pkg::ST_CONN | urh_pkg::ST_ENABLE | urh_pkg::ST_LOW |
                                   urh_pkg::ST_HIGH | urh_pkg::ST_SUSP);
                2'd1:    r = r | urh_pkg::ST_CONN | urh_pkg::ST_LOW;
                2'd2:    r = r | urh_pkg::ST_CONN;
                default: r = r | urh_pkg::ST_CONN | urh_pkg::ST_HIGH;
            endcase
            r = r | urh_pkg::CH_CONN;
        end
        return r;
    endfunction

    assign nu      = ({1'b0, port_count_reg} < 5'(MAX_PORTS)) ? {1'b0, port_count_reg}
                                                               : 5'(MAX_PORTS);
    assign port_ok = (pn_reg != 5'd0) && (pn_reg <= nu);
    assign p       = port_ok ? PW'(pn_reg - 5'd1) : '0;
    assign s       = st_reg[p];
    assign d       = dev_reg[p];
    assign sp      = spd_reg[p];

    // Update of the addressed port.
    always_comb
    begin
        ns  = s;
        nd  = d;
        nsp = sp;
        nl  = lat_reg[p];
        nr  = rsm_reg[p];
        nc  = cd_reg[p];
        wr  = 1'b0;
        case (func_reg)
            urh_pkg::FN_CONNECT:
            begin
                if (port_ok && !speed_reg[2] && (sp != speed_reg[1:0]))
                begin
                    wr  = 1'b1;
                    nd  = (speed_reg[1:0] == urh_pkg::SPD_NONE) ? urh_pkg::DEV_NONE
                                                                : urh_pkg::DEV_ATTACHED;
                    nsp = speed_reg[1:0];
                    nl  = 1'b1;
                    ns  = apply_connect(s, speed_reg[1:0]);
                end
            end
            urh_pkg::FN_CLR_PORT:
            begin
                wr = port_ok;
                case (feat_reg)
                    urh_pkg::FEAT_SUSPEND:
                    begin
                        if (s[2])
                        begin
                            nr = 1'b1;
                            nc = resume_ticks_reg;
                        end
                    end
                    urh_pkg::FEAT_POWER:
                    begin
                        if (s[8])
                        begin
                            ns = '0;
                            if (d != urh_pkg::DEV_NONE)
                            begin
                                nd = urh_pkg::DEV_ATTACHED;
                            end
                        end
                    end
                    urh_pkg::FEAT_ENABLE:
                    begin
                        ns = s & ~(urh_pkg::ST_ENABLE | urh_pkg::ST_SUSP);
                        nr = 1'b0;
                        if (d != urh_pkg::DEV_NONE)
                        begin
                            nd = urh_pkg::DEV_POWERED;
                        end
                    end
                    default:
                    begin
                        if (feat_reg == urh_pkg::FEAT_C_CONN)
                        begin
                            nl = 1'b0;
                        end
                        ns = s & ~(32'd1 << feat_reg);
                    end
                endcase
            end
            urh_pkg::FN_SET_PORT:
            begin
                wr = port_ok;
                case (feat_reg)
                    urh_pkg::FEAT_POWER:
                    begin
                        if (!s[8])
                        begin
                            ns = s | urh_pkg::ST_POWER;
                            if (d != urh_pkg::DEV_NONE)
                            begin
                                nd = urh_pkg::DEV_POWERED;
                            end
                            if (lat_reg[p])
                            begin
                                ns = apply_connect(s | urh_pkg::ST_POWER, sp);
                            end
                        end
                    end
                    urh_pkg::FEAT_RESET:
                    begin
                        ns = (s & ~(urh_pkg::ST_ENABLE | urh_pkg::ST_LOW | urh_pkg::ST_HIGH))
                             | urh_pkg::ST_RESET;
                        if (d != urh_pkg::DEV_NONE)
                        begin
                            nd = urh_pkg::DEV_ATTACHED;
                        end
                        nc = reset_ticks_reg;
                    end
                    urh_pkg::FEAT_SUSPEND:
                    begin
                        ns = s | urh_pkg::ST_SUSP;
                        nd = urh_pkg::DEV_SUSP;
                    end
                    default:
                    begin
                        if (s[8])
                        begin
                            ns = s | (32'd1 << feat_reg);
                        end
                    end
                endcase
            end
            urh_pkg::FN_GET_PORT:
            begin
                // Reset and resume completion are applied when the port is read.
                wr = port_ok;
                if (rsm_reg[p] && (cd_reg[p] == 16'd0))
                begin
                    ns = (ns | urh_pkg::CH_SUSP) & ~urh_pkg::ST_SUSP;
                    nr = 1'b0;
                end
                if (ns[4] && (cd_reg[p] == 16'd0))
                begin
                    ns = (ns | urh_pkg::CH_RESET) & ~urh_pkg::ST_RESET;
                    if (d != urh_pkg::DEV_NONE)
                    begin
                        ns = ns | urh_pkg::ST_ENABLE;
                        nd = urh_pkg::DEV_DEFAULT;
                    end
                    if (sp == urh_pkg::SPD_LOW)
                    begin
                        ns = ns | urh_pkg::ST_LOW;
                    end
                    else if (sp == urh_pkg::SPD_HIGH)
                    begin
                        ns = ns | urh_pkg::ST_HIGH;
                    end
                end
            end
            default:
            begin
                wr = 1'b0;
            end
        endcase
    end

    // Stall, change summary and poll bitmap.
    always_comb
    begin
        stall_next  = 1'b0;
        hub_req     = 1'b1;
        pend_next   = 1'b0;
        bitmap_next = '0;
        chosen      = '0;
        case (func_reg) inside
            urh_pkg::FN_CONNECT, urh_pkg::FN_POLL, urh_pkg::FN_TICK: hub_req = 1'b0;
            urh_pkg::FN_CLR_HUB, urh_pkg::FN_GET_HUB:                hub_req = 1'b1;
            urh_pkg::FN_CLR_PORT, urh_pkg::FN_SET_PORT, urh_pkg::FN_GET_PORT:
                stall_next = !port_ok;
            default: stall_next = 1'b1;
        endcase
        for (int i = 0; i < MAX_PORTS; i++)
        begin
            chosen = (wr && (p == PW'(i))) ? ns : st_reg[i];
            if ((5'(i) < nu) && (chosen[20:16] != 5'd0))
            begin
                pend_next = 1'b1;
            end
            if (running_reg && (func_reg == urh_pkg::FN_POLL) && (i + 1 < BM) &&
                (5'(i) < nu) && (st_reg[i][20:16] != 5'd0))
            begin
                bitmap_next[i + 1] = 1'b1;
            end
        end
        pend_next  = pend_next && hub_req;
        bytes_next = (bitmap_next != '0) ? 3'(3'd1 + 3'(nu >> 3)) : 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_count_reg   <= 4'd8;
            running_reg      <= 1'b1;
            reset_ticks_reg  <= 16'd10;
            resume_ticks_reg <= 16'd20;
            for (int i = 0; i < MAX_PORTS; i++)
            begin
                st_reg[i]  <= '0;
                dev_reg[i] <= urh_pkg::DEV_NONE;
                spd_reg[i] <= urh_pkg::SPD_NONE;
                lat_reg[i] <= 1'b0;
                rsm_reg[i] <= 1'b0;
                cd_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    urh_pkg::CFG_PORT_COUNT:  port_count_reg   <= cfg_data[3:0];
                    urh_pkg::CFG_RUNNING:     running_reg      <= cfg_data[0];
                    urh_pkg::CFG_RESET_TICK:  reset_ticks_reg  <= cfg_data;
                    default:                  resume_ticks_reg <= cfg_data;
                endcase
            end
            if (cmd.execute)
            begin
                if (func_reg == urh_pkg::FN_TICK)
                begin
                    for (int i = 0; i < MAX_PORTS; i++)
                    begin
                        if (cd_reg[i] != 16'd0)
                        begin
                            cd_reg[i] <= cd_reg[i] - 16'd1;
                        end
                    end
                end
                else if (wr)
                begin
                    st_reg[p]  <= ns;
                    dev_reg[p] <= nd;
                    spd_reg[p] <= nsp;
                    lat_reg[p] <= nl;
                    rsm_reg[p] <= nr;
                    cd_reg[p]  <= nc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            pn_reg    <= port_number;
            feat_reg  <= feature;
            speed_reg <= device_speed;
        end
        if (cmd.execute)
        begin
            stall_reg  <= stall_next;
            status_reg <= (func_reg == urh_pkg::FN_GET_PORT && port_ok) ? ns[15:0] : 16'd0;
            change_reg <= (func_reg == urh_pkg::FN_GET_PORT && port_ok) ? ns[31:16] : 16'd0;
            bitmap_reg <= bitmap_next;
            bytes_reg  <= bytes_next;
            pend_reg   <= pend_next;
        end
    end

    assign stall_res      = stall_reg;
    assign port_status    = status_reg;
    assign port_change    = change_reg;
    assign change_bitmap  = bitmap_reg;
    assign bitmap_bytes   = bytes_reg;
    assign change_pending = pend_reg;

endmodule

FILE: rtl/core/usb_root_hub_port_control.sv
// ============================================================================
// USB 2.0 root hub port control
// Per-port status, change, device state and reset/resume countdowns for a
// root hub, driven by connect events, hub requests, polls and 1 ms ticks.
// ============================================================================
//
// Channel    Handshake            Carries
// request    start / busy         func, port_number, feature, device_speed
// result     done (one cycle)     stall_res, port_status, port_change,
//                                 change_bitmap, bitmap_bytes, change_pending
// config     cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each request passes through capture, execute and the result state, and
// no new request is taken before the block is idle. The execute cycle
// updates the addressed port in one step; a tick lowers all countdowns at
// once. Reset brings every port to unpowered and empty with the default
// configuration. The result stands for exactly one cycle with done high,
// and the receiver cannot stall it. Configuration is always ready.
module usb_root_hub_port_control #(
    parameter int MAX_PORTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  func,
    input  logic [4:0]  port_number,
    input  logic [4:0]  feature,
    input  logic [2:0]  device_speed,
    output logic        done,
    output logic        stall_res,
    output logic [15:0] port_status,
    output logic [15:0] port_change,
    output logic [8:0]  change_bitmap,
    output logic [2:0]  bitmap_bytes,
    output logic        change_pending,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    urh_pkg::urh_cmd_t cmd;

    // Configuration writes are taken in any cycle; the user must send them only
    // while no transfer is in flight, as the block itself does not enforce it.
    assign cfg_ready = 1'b1;

    urh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    urh_dpath #(
        .MAX_PORTS (MAX_PORTS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .func           (func),
        .port_number    (port_number),
        .feature        (feature),
        .device_speed   (device_speed),
        .stall_res      (stall_res),
        .port_status    (port_status),
        .port_change    (port_change),
        .change_bitmap  (change_bitmap),
        .bitmap_bytes   (bitmap_bytes),
        .change_pending (change_pending)
    );

endmodule

FILE: rtl/core/urh_chk.sv
// ============================================================================
// Root hub port control checker
// Watches the top-level ports for sequencing and result consistency.
// ============================================================================
module urh_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        stall_res,
    input logic [15:0] port_status,
    input logic [15:0] port_change,
    input logic [8:0]  change_bitmap,
    input logic [2:0]  bitmap_bytes
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_done_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result without a transfer in flight");

    a_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && stall_res) |-> (port_status == 16'd0 && port_change == 16'd0))
        else $error("stalled request returned port words");

    a_poll_len: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((bitmap_bytes == 3'd0) == (change_bitmap == 9'd0)))
        else $error("poll length disagrees with bitmap");

endmodule

bind usb_root_hub_port_control urh_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .stall_res     (stall_res),
    .port_status   (port_status),
    .port_change   (port_change),
    .change_bitmap (change_bitmap),
    .bitmap_bytes  (bitmap_bytes)
);

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// Root hub port control testbench
// Sends connect events, hub requests, polls and ticks to the root hub, keeps
// its own model of every port and checks each result field by field.
// ============================================================================
module testbench;

    localparam int NPORT = 8;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic        stall;
        logic [15:0] status;
        logic [15:0] change;
        logic [8:0]  bitmap;
        logic [2:0]  nbytes;
        logic        pending;
    } hub_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  func = '0;
    logic [4:0]  port_number = '0;
    logic [4:0]  feature = '0;
    logic [2:0]  device_speed = '0;
    logic        done;
    logic        stall_res;
    logic [15:0] port_status;
    logic [15:0] port_change;
    logic [8:0]  change_bitmap;
    logic [2:0]  bitmap_bytes;
    logic        change_pending;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    usb_root_hub_port_control dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Model state: configuration and per-port registers.
    logic [3:0]  m_port_count;
    logic        m_running;
    logic [15:0] m_reset_ticks;
    logic [15:0] m_resume_ticks;
    logic [31:0] m_bits [NPORT];
    logic [2:0]  m_dev [NPORT];
    logic [1:0]  m_speed [NPORT];
    logic        m_latched [NPORT];
    logic        m_resuming [NPORT];
    logic [15:0] m_count [NPORT];

    hub_result_t expected_results[$];
    int errors = 0;
    int transfers = 0;
    int results_seen = 0;
    int idle_cycles = 0;

    function automatic int used_ports();
        return (m_port_count < NPORT) ? int'(m_port_count) : NPORT;
    endfunction

    function automatic bit valid_port(logic [4:0] pn);
        return pn >= 1 && int'(pn) <= used_ports();
    endfunction

    function automatic void model_reset();
        m_port_count = 4'd8;
        m_running = 1'b1;
        m_reset_ticks = 16'd10;
        m_resume_ticks = 16'd20;
        for (int i = 0; i < NPORT; i++)
        begin
            m_bits[i] = '0;
            m_dev[i] = urh_pkg::DEV_NONE;
            m_speed[i] = urh_pkg::SPD_NONE;
            m_latched[i] = 1'b0;
            m_resuming[i] = 1'b0;
            m_count[i] = '0;
        end
    endfunction

    // Reflect a latched connect into the status word of a powered port.
    function automatic void show_connect(int p);
        if ((m_bits[p] & urh_pkg::ST_POWER) == 0)
            return;
        case (m_speed[p])
            urh_pkg::SPD_NONE:
                m_bits[p] &= ~(urh_pkg::ST_CONN | urh_pkg::ST_ENABLE | urh_pkg::ST_LOW |
                               urh_pkg::ST_HIGH | urh_pkg::ST_SUSP);
            urh_pkg::SPD_LOW:  m_bits[p] |= urh_pkg::ST_CONN | urh_pkg::ST_LOW;
            urh_pkg::SPD_HIGH: m_bits[p] |= urh_pkg::ST_CONN | urh_pkg::ST_HIGH;
            default:           m_bits[p] |= urh_pkg::ST_CONN;
        endcase
        m_bits[p] |= urh_pkg::CH_CONN;
    endfunction

    // Reset and resume complete only when the port status is read.
    function automatic void complete_timers(int p);
        if (m_resuming[p] && m_count[p] == 0)
        begin
            m_bits[p] |= urh_pkg::CH_SUSP;
            m_bits[p] &= ~urh_pkg::ST_SUSP;
            m_resuming[p] = 1'b0;
        end
        if ((m_bits[p] & urh_pkg::ST_RESET) != 0 && m_count[p] == 0)
        begin
            m_bits[p] |= urh_pkg::CH_RESET;
            m_bits[p] &= ~urh_pkg::ST_RESET;
            if (m_dev[p] != urh_pkg::DEV_NONE)
            begin
                m_bits[p] |= urh_pkg::ST_ENABLE;
                m_dev[p] = urh_pkg::DEV_DEFAULT;
            end
            if (m_speed[p] == urh_pkg::SPD_LOW)
                m_bits[p] |= urh_pkg::ST_LOW;
            else if (m_speed[p] == urh_pkg::SPD_HIGH)
                m_bits[p] |= urh_pkg::ST_HIGH;
        end
    endfunction

    function automatic void clear_port_feature(int p, logic [4:0] f);
        case (f)
            urh_pkg::FEAT_SUSPEND:
                if ((m_bits[p] & urh_pkg::ST_SUSP) != 0)
                begin
                    m_resuming[p] = 1'b1;
                    m_count[p] = m_resume_ticks;
                end
            urh_pkg::FEAT_POWER:
                if ((m_bits[p] & urh_pkg::ST_POWER) != 0)
                begin
                    m_bits[p] = '0;
                    if (m_dev[p] != urh_pkg::DEV_NONE)
                        m_dev[p] = urh_pkg::DEV_ATTACHED;
                end
            urh_pkg::FEAT_ENABLE:
            begin
                m_bits[p] &= ~(urh_pkg::ST_ENABLE | urh_pkg::ST_SUSP);
                m_resuming[p] = 1'b0;
                if (m_dev[p] != urh_pkg::DEV_NONE)
                    m_dev[p] = urh_pkg::DEV_POWERED;
            end
            default:
            begin
                if (f == urh_pkg::FEAT_C_CONN)
                    m_latched[p] = 1'b0;
                m_bits[p] &= ~(32'd1 << f);
            end
        endcase
    endfunction

    function automatic void set_port_feature(int p, logic [4:0] f);
        case (f)
            urh_pkg::FEAT_POWER:
                if ((m_bits[p] & urh_pkg::ST_POWER) == 0)
                begin
                    m_bits[p] |= urh_pkg::ST_POWER;
                    if (m_dev[p] != urh_pkg::DEV_NONE)
                        m_dev[p] = urh_pkg::DEV_POWERED;
                    if (m_latched[p])
                        show_connect(p);
                end
            urh_pkg::FEAT_RESET:
            begin
                m_bits[p] &= ~(urh_pkg::ST_ENABLE | urh_pkg::ST_LOW | urh_pkg::ST_HIGH);
                m_bits[p] |= urh_pkg::ST_RESET;
                if (m_dev[p] != urh_pkg::DEV_NONE)
                    m_dev[p] = urh_pkg::DEV_ATTACHED;
                m_count[p] = m_reset_ticks;
            end
            urh_pkg::FEAT_SUSPEND:
            begin
                m_bits[p] |= urh_pkg::ST_SUSP;
                m_dev[p] = urh_pkg::DEV_SUSP;
            end
            default:
                if ((m_bits[p] & urh_pkg::ST_POWER) != 0)
                    m_bits[p] |= 32'd1 << f;
        endcase
    endfunction

    // Computes the hub's answer to one request and updates the port model.
    function automatic hub_result_t hub_answer(logic [3:0] fn, logic [4:0] pn,
                                               logic [4:0] f, logic [2:0] spd);
        hub_result_t r;
        bit ok;
        bit hub_req;
        int p;
        int n;
        r = '0;
        ok = valid_port(pn);
        p = ok ? int'(pn) - 1 : 0;
        n = used_ports();
        hub_req = 1'b0;
        case (fn) inside
            urh_pkg::FN_CONNECT:
                if (ok && spd <= 3 && {1'b0, m_speed[p]} != spd)
                begin
                    m_dev[p] = (spd == 0) ? urh_pkg::DEV_NONE : urh_pkg::DEV_ATTACHED;
                    m_speed[p] = spd[1:0];
                    m_latched[p] = 1'b1;
                    show_connect(p);
                end
            urh_pkg::FN_CLR_HUB, urh_pkg::FN_GET_HUB:
                hub_req = 1'b1;
            urh_pkg::FN_CLR_PORT, urh_pkg::FN_SET_PORT:
            begin
                hub_req = 1'b1;
                if (!ok)
                    r.stall = 1'b1;
                else if (fn == urh_pkg::FN_CLR_PORT)
                    clear_port_feature(p, f);
                else
                    set_port_feature(p, f);
            end
            urh_pkg::FN_GET_PORT:
            begin
                hub_req = 1'b1;
                if (!ok)
                    r.stall = 1'b1;
                else
                begin
                    complete_timers(p);
                    r.status = m_bits[p][15:0];
                    r.change = m_bits[p][31:16];
                end
            end
            urh_pkg::FN_POLL:
                if (m_running)
                begin
                    for (int i = 0; i < n; i++)
                        if (m_bits[i][20:16] != 0)
                            r.bitmap[i + 1] = 1'b1;
                    if (r.bitmap != 0)
                        r.nbytes = 3'(1 + n / 8);
                end
            urh_pkg::FN_TICK:
                for (int i = 0; i < NPORT; i++)
                    if (m_count[i] != 0)
                        m_count[i]--;
            default:
            begin
                hub_req = 1'b1;
                r.stall = 1'b1;
            end
        endcase
        if (hub_req)
            for (int i = 0; i < n; i++)
                if (m_bits[i][20:16] != 0)
                    r.pending = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // Gap of random length: mostly none or short, now and then long.
    task automatic random_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50)
            return;
        repeat (k < 90 ? $urandom_range(1, 3) : $urandom_range(5, 30))
            @(negedge clk);
    endtask

    // Sends one request and waits for the transfer to happen.
    task automatic send_request(logic [3:0] fn, logic [4:0] pn, logic [4:0] f,
                                logic [2:0] spd);
        start = 1'b1;
        func = fn;
        port_number = pn;
        feature = f;
        device_speed = spd;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        expected_results.push_back(hub_answer(fn, pn, f, spd));
        transfers++;
        @(negedge clk);
        start = 1'b0;
        random_gap();
    endtask

    task automatic wait_quiet();
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (5)
            @(negedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            urh_pkg::CFG_PORT_COUNT:  m_port_count = value[3:0];
            urh_pkg::CFG_RUNNING:     m_running = value[0];
            urh_pkg::CFG_RESET_TICK:  m_reset_ticks = value;
            default:                  m_resume_ticks = value;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(logic [3:0] ports, logic run, logic [15:0] rst_t,
                             logic [15:0] res_t);
        wait_quiet();
        write_register(urh_pkg::CFG_PORT_COUNT, {12'd0, ports});
        write_register(urh_pkg::CFG_RUNNING, {15'd0, run});
        write_register(urh_pkg::CFG_RESET_TICK, rst_t);
        write_register(urh_pkg::CFG_RESUME_TICK, res_t);
    endtask

    // Checker: every result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        hub_result_t want;
        if (done)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (stall_res !== want.stall)
                    report_mismatch("stall_res", stall_res, want.stall);
                if (port_status !== want.status)
                    report_mismatch("port_status", port_status, want.status);
                if (port_change !== want.change)
                    report_mismatch("port_change", port_change, want.change);
                if (change_bitmap !== want.bitmap)
                    report_mismatch("change_bitmap", change_bitmap, want.bitmap);
                if (bitmap_bytes !== want.nbytes)
                    report_mismatch("bitmap_bytes", bitmap_bytes, want.nbytes);
                if (change_pending !== want.pending)
                    report_mismatch("change_pending", change_pending, want.pending);
            end
        end
    end

    // Watchdog on cycles with no transfer at all.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Directed: each request kind, extreme fields, stalls and ignored events.
    task automatic test_directed();
        send_request(urh_pkg::FN_SET_PORT, 5'd1, urh_pkg::FEAT_POWER, 3'd0);
        send_request(urh_pkg::FN_CONNECT, 5'd1, 5'd0, 3'd3);
        send_request(urh_pkg::FN_CONNECT, 5'd1, 5'd0, 3'd3);
        send_request(urh_pkg::FN_CONNECT, 5'd1, 5'd0, 3'd7);
        send_request(urh_pkg::FN_CONNECT, 5'd0, 5'd0, 3'd1);
        send_request(urh_pkg::FN_CONNECT, 5'd31, 5'd0, 3'd2);
        send_request(urh_pkg::FN_POLL, 5'd0, 5'd0, 3'd0);
        send_request(urh_pkg::FN_SET_PORT, 5'd1, urh_pkg::FEAT_RESET, 3'd0);
        send_request(urh_pkg::FN_GET_PORT, 5'd1, 5'd0, 3'd0);
        repeat (10)
            send_request(urh_pkg::FN_TICK, 5'd0, 5'd0, 3'd0);
        send_request(urh_pkg::FN_GET_PORT, 5'd1, 5'd0, 3'd0);
        send_request(urh_pkg::FN_SET_PORT, 5'd1, urh_pkg::FEAT_SUSPEND, 3'd0);
        send_request(urh_pkg::FN_CLR_PORT, 5'd1, urh_pkg::FEAT_SUSPEND, 3'd0);
        send_request(urh_pkg::FN_SET_PORT, 5'd1, 5'd31, 3'd0);
        send_request(urh_pkg::FN_CLR_PORT, 5'd1, urh_pkg::FEAT_C_CONN, 3'd0);
        send_request(urh_pkg::FN_SET_HUB, 5'd1, 5'd0, 3'd0);
        send_request(4'd15, 5'd31, 5'd31, 3'd7);
        send_request(urh_pkg::FN_GET_PORT, 5'd0, 5'd0, 3'd0);
        send_request(urh_pkg::FN_CLR_HUB, 5'd0, 5'd0, 3'd0);
        send_request(urh_pkg::FN_GET_HUB, 5'd0, 5'd0, 3'd0);
        send_request(urh_pkg::FN_CLR_PORT, 5'd1, urh_pkg::FEAT_ENABLE, 3'd0);
        send_request(urh_pkg::FN_CLR_PORT, 5'd1, urh_pkg::FEAT_POWER, 3'd0);
    endtask

    // Random: mostly well-formed bring-up sequences on one port, plus noise.
    task automatic test_random(int count, int max_port);
        int sent;
        int ticks;
        logic [4:0] pn;
        sent = 0;
        while (sent < count)
        begin
            pn = 5'($urandom_range(1, max_port));
            if ($urandom_range(0, 3) != 0)
            begin
                send_request(urh_pkg::FN_CONNECT, pn, 5'd0, 3'($urandom_range(0, 3)));
                send_request(urh_pkg::FN_SET_PORT, pn, urh_pkg::FEAT_POWER, 3'($urandom));
                send_request(urh_pkg::FN_POLL, 5'($urandom), 5'($urandom), 3'($urandom));
                send_request(urh_pkg::FN_SET_PORT, pn, $urandom_range(0, 1) ?
                             urh_pkg::FEAT_RESET : urh_pkg::FEAT_SUSPEND, 3'd0);
                sent += 4;
                if ($urandom_range(0, 1))
                begin
                    send_request(urh_pkg::FN_CLR_PORT, pn, urh_pkg::FEAT_SUSPEND, 3'd0);
                    sent++;
                end
                ticks = $urandom_range(0, 12);
                repeat (ticks)
                    send_request(urh_pkg::FN_TICK, 5'($urandom), 5'($urandom),
                                 3'($urandom));
                sent += ticks;
                send_request(urh_pkg::FN_GET_PORT, pn, 5'd0, 3'd0);
                send_request(urh_pkg::FN_CLR_PORT, pn, 5'($urandom_range(16, 20)), 3'd0);
                sent += 2;
            end
            else
            begin
                send_request(4'($urandom), 5'($urandom), 5'($urandom), 3'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        model_reset();
        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(250, 8);
        // Few ports, stopped controller, instant reset and resume.
        configure(4'd1, 1'b0, 16'd0, 16'd0);
        test_random(120, 3);
        // Out-of-range port count and the longest timers.
        configure(4'd15, 1'b1, 16'hFFFF, 16'hFFFF);
        test_random(80, 8);
        configure(4'd3, 1'b1, 16'd2, 16'd5);
        test_random(250, 5);
        wait_quiet();
        $display("Covered %0d request transfers and %0d results over four settings.",
                 transfers, results_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

FILE: usb_root_hub_port_control.f
rtl/core/urh_pkg.sv
rtl/core/urh_ctrl.sv
rtl/core/urh_dpath.sv
rtl/core/usb_root_hub_port_control.sv
rtl/core/urh_chk.sv
test/testbench.sv
